>>> hw/rtl/two_task_tick_scheduler_top_assert.svh
// Assertion macros for the tick scheduler. Each macro expects clk and rst_n in scope.
`ifndef TWO_TASK_TICK_SCHEDULER_TOP_ASSERT_SVH
`define TWO_TASK_TICK_SCHEDULER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTTS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tick scheduler check failed");

// The consequent must hold in the cycle after the antecedent.
`define TTTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tick scheduler check failed");

`endif

>>> hw/rtl/ttts_pkg.sv
`default_nettype none

package ttts_pkg;

  localparam int SpWidth = 32;

  typedef logic [SpWidth-1:0] sp_t;

  typedef enum logic {
    MODE_TICK  = 1'b0,
    MODE_DELAY = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    TASK_START = 2'd0,
    TASK_ONE   = 2'd1,
    TASK_TWO   = 2'd2,
    TASK_IDLE  = 2'd3
  } task_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_ZERO_DELAY = 2'd1,
    ST_FAULT      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_TASK1_SP = 2'd0,
    CFG_TASK2_SP = 2'd1,
    CFG_IDLE_SP  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SLOT_ONE  = 2'd0,
    SLOT_TWO  = 2'd1,
    SLOT_IDLE = 2'd2
  } slot_t;

endpackage

`default_nettype wire

>>> hw/rtl/two_task_tick_scheduler_top.sv
// A result is presented once its input transaction has passed through the input register
// and then the result register; a stall on the output can hold it in between.
// Throughput: one transaction per cycle while out_stall is low; the scheduler state updates as
// each item moves from the input register into the result register.
// Reset (rst_n low, synchronous): start context, both tasks runnable, counts zero,
// initial stack pointers zero, no saved pointers, both stages empty.
`default_nettype none

`include "two_task_tick_scheduler_top_assert.svh"

module two_task_tick_scheduler_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_mode,
  input  wire logic [31:0] in_saved_sp,
  input  wire logic [31:0] in_delay_ticks,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_next_sp,
  output logic [1:0]       out_next_task,
  output logic [1:0]       out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // Configuration registers.
  ttts_pkg::sp_t task1_init_r, task2_init_r, idle_init_r;

  // Input stage.
  logic              s1_valid_r;
  ttts_pkg::mode_t   s1_mode_r;
  ttts_pkg::sp_t     s1_sp_r;
  ttts_pkg::sp_t     s1_delay_r;

  // Scheduler state.
  ttts_pkg::task_t   running_r, running_nxt;
  logic              t1_blocked_r, t1_blocked_nxt;
  logic              t2_blocked_r, t2_blocked_nxt;
  ttts_pkg::sp_t     t1_rem_r, t1_rem_nxt;
  ttts_pkg::sp_t     t2_rem_r, t2_rem_nxt;
  ttts_pkg::sp_t     saved_one_r, saved_two_r, saved_idle_r;
  logic [2:0]        saved_flags_r, saved_flags_nxt;

  // Result stage.
  logic              out_valid_r;
  ttts_pkg::sp_t     out_sp_r, out_sp_nxt;
  ttts_pkg::task_t   out_task_r;
  ttts_pkg::status_t out_status_r, out_status_nxt;

  logic              out_space;
  logic              s1_advance;
  logic              in_take;
  logic              save_en;
  ttts_pkg::slot_t   save_slot;
  ttts_pkg::slot_t   next_slot;
  ttts_pkg::task_t   next_task;
  ttts_pkg::sp_t     t1_dec, t2_dec;
  logic              t1_after, t2_after;
  ttts_pkg::sp_t     slot_saved_sp, slot_init_sp;
  logic              slot_flag;

  assign cfg_ready  = 1'b1;
  assign out_space  = !out_valid_r || !out_stall;
  assign s1_advance = s1_valid_r && out_space;
  assign in_stall   = s1_valid_r && !out_space;
  assign in_take    = in_valid && !in_stall;

  assign out_valid     = out_valid_r;
  assign out_next_sp   = out_sp_r;
  assign out_next_task = out_task_r;
  assign out_status    = out_status_r;

  // Countdown of blocked tasks as seen by a tick.
  assign t1_dec   = t1_rem_r - 32'd1;
  assign t2_dec   = t2_rem_r - 32'd1;
  assign t1_after = t1_blocked_r && (t1_dec != 32'd0);
  assign t2_after = t2_blocked_r && (t2_dec != 32'd0);

  always_comb begin
    save_en   = 1'b1;
    save_slot = ttts_pkg::SLOT_ONE;
    next_task = ttts_pkg::TASK_ONE;
    case (running_r)
      ttts_pkg::TASK_START: begin
        save_en   = 1'b0;
        next_task = ttts_pkg::TASK_ONE;
      end
      ttts_pkg::TASK_ONE: begin
        save_slot = ttts_pkg::SLOT_ONE;
        next_task = !t2_after ? ttts_pkg::TASK_TWO :
                    (!t1_after ? ttts_pkg::TASK_ONE : ttts_pkg::TASK_IDLE);
      end
      ttts_pkg::TASK_TWO: begin
        save_slot = ttts_pkg::SLOT_TWO;
        next_task = !t1_after ? ttts_pkg::TASK_ONE :
                    (!t2_after ? ttts_pkg::TASK_TWO : ttts_pkg::TASK_IDLE);
      end
      default: begin
        save_slot = ttts_pkg::SLOT_IDLE;
        next_task = !t1_after ? ttts_pkg::TASK_ONE :
                    (!t2_after ? ttts_pkg::TASK_TWO : ttts_pkg::TASK_IDLE);
      end
    endcase
  end

  always_comb begin
    case (next_task)
      ttts_pkg::TASK_ONE: next_slot = ttts_pkg::SLOT_ONE;
      ttts_pkg::TASK_TWO: next_slot = ttts_pkg::SLOT_TWO;
      default:            next_slot = ttts_pkg::SLOT_IDLE;
    endcase
    case (next_slot)
      ttts_pkg::SLOT_ONE: begin
        slot_saved_sp = saved_one_r;
        slot_init_sp  = task1_init_r;
        slot_flag     = saved_flags_r[0];
      end
      ttts_pkg::SLOT_TWO: begin
        slot_saved_sp = saved_two_r;
        slot_init_sp  = task2_init_r;
        slot_flag     = saved_flags_r[1];
      end
      default: begin
        slot_saved_sp = saved_idle_r;
        slot_init_sp  = idle_init_r;
        slot_flag     = saved_flags_r[2];
      end
    endcase
  end

  always_comb begin
    running_nxt     = running_r;
    t1_blocked_nxt  = t1_blocked_r;
    t2_blocked_nxt  = t2_blocked_r;
    t1_rem_nxt      = t1_rem_r;
    t2_rem_nxt      = t2_rem_r;
    saved_flags_nxt = saved_flags_r;
    out_sp_nxt      = '0;
    out_status_nxt  = ttts_pkg::ST_DONE;
    if (s1_mode_r == ttts_pkg::MODE_TICK) begin
      t1_blocked_nxt = t1_after;
      t2_blocked_nxt = t2_after;
      if (t1_blocked_r) begin
        t1_rem_nxt = t1_dec;
      end
      if (t2_blocked_r) begin
        t2_rem_nxt = t2_dec;
      end
      running_nxt = next_task;
      if (save_en) begin
        saved_flags_nxt[save_slot] = 1'b1;
      end
      // The pointer saved by this very tick wins over the stored copy.
      if (save_en && (save_slot == next_slot)) begin
        out_sp_nxt = s1_sp_r;
      end else if (slot_flag) begin
        out_sp_nxt = slot_saved_sp;
      end else begin
        out_sp_nxt = slot_init_sp;
      end
    end else begin
      if (s1_delay_r == 32'd0) begin
        out_status_nxt = ttts_pkg::ST_ZERO_DELAY;
      end else if (running_r == ttts_pkg::TASK_ONE) begin
        t1_blocked_nxt = 1'b1;
        t1_rem_nxt     = s1_delay_r;
      end else if (running_r == ttts_pkg::TASK_TWO) begin
        t2_blocked_nxt = 1'b1;
        t2_rem_nxt     = s1_delay_r;
      end else begin
        out_status_nxt = ttts_pkg::ST_FAULT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task1_init_r <= '0;
      task2_init_r <= '0;
      idle_init_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (ttts_pkg::cfg_idx_t'(cfg_index))
        ttts_pkg::CFG_TASK1_SP: task1_init_r <= cfg_data;
        ttts_pkg::CFG_TASK2_SP: task2_init_r <= cfg_data;
        ttts_pkg::CFG_IDLE_SP:  idle_init_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r  <= ttts_pkg::mode_t'(in_mode);
      s1_sp_r    <= in_saved_sp;
      s1_delay_r <= in_delay_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r     <= ttts_pkg::TASK_START;
      t1_blocked_r  <= 1'b0;
      t2_blocked_r  <= 1'b0;
      t1_rem_r      <= '0;
      t2_rem_r      <= '0;
      saved_flags_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (s1_advance) begin
        running_r     <= running_nxt;
        t1_blocked_r  <= t1_blocked_nxt;
        t2_blocked_r  <= t2_blocked_nxt;
        t1_rem_r      <= t1_rem_nxt;
        t2_rem_r      <= t2_rem_nxt;
        saved_flags_r <= saved_flags_nxt;
      end
      if (out_space) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Stored pointers have no reset; the flags decide when they are read.
  always_ff @(posedge clk) begin
    if (s1_advance && (s1_mode_r == ttts_pkg::MODE_TICK) && save_en) begin
      case (save_slot)
        ttts_pkg::SLOT_ONE: saved_one_r  <= s1_sp_r;
        ttts_pkg::SLOT_TWO: saved_two_r  <= s1_sp_r;
        default:            saved_idle_r <= s1_sp_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_sp_r     <= out_sp_nxt;
      out_task_r   <= running_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  `TTTS_ASSERT_SAME(a_t1_count_live, t1_blocked_r, t1_rem_r != 32'd0)
  `TTTS_ASSERT_SAME(a_t2_count_live, t2_blocked_r, t2_rem_r != 32'd0)
  `TTTS_ASSERT_NEXT(a_no_return_to_start, running_r != ttts_pkg::TASK_START,
                    running_r != ttts_pkg::TASK_START)
  `TTTS_ASSERT_SAME(a_fault_context, out_valid_r && (out_status_r == ttts_pkg::ST_FAULT),
                    (out_sp_r == 32'd0) && ((out_task_r == ttts_pkg::TASK_START) ||
                    (out_task_r == ttts_pkg::TASK_IDLE)))
  `TTTS_ASSERT_SAME(a_ignored_delay_zero_sp,
                    out_valid_r && (out_status_r == ttts_pkg::ST_ZERO_DELAY),
                    out_sp_r == 32'd0)

endmodule

`default_nettype wire

>>> dv/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 2000;

  typedef struct packed {
    ttts_pkg::mode_t mode;
    ttts_pkg::sp_t   saved_sp;
    logic [31:0]     delay_ticks;
  } sched_req_t;

  typedef struct packed {
    ttts_pkg::sp_t     next_sp;
    ttts_pkg::task_t   next_task;
    ttts_pkg::status_t status;
  } switch_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_mode = 1'b0;
  logic [31:0] in_saved_sp = '0;
  logic [31:0] in_delay_ticks = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_next_sp;
  logic [1:0]  out_next_task;
  logic [1:0]  out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  two_task_tick_scheduler_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_saved_sp    (in_saved_sp),
    .in_delay_ticks (in_delay_ticks),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_next_sp    (out_next_sp),
    .out_next_task  (out_next_task),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #10 clk = ~clk;

  sched_req_t pending_requests[$];
  switch_t    expected_switches[$];
  int         errors = 0;
  logic       quiet = 1'b0;
  int         in_gap = 0;
  int         out_gap = 0;
  int         idle_cycles = 0;

  // Scheduler state as the testbench sees it. Index 0 is task one, 1 is task two.
  ttts_pkg::task_t cur_task = ttts_pkg::TASK_START;
  logic            task_blocked [2] = '{1'b0, 1'b0};
  logic [31:0]     ticks_left [2] = '{32'd0, 32'd0};
  ttts_pkg::sp_t   stored_sp [3] = '{'0, '0, '0};
  logic            sp_stored [3] = '{1'b0, 1'b0, 1'b0};
  ttts_pkg::sp_t   boot_sp [3] = '{'0, '0, '0};

  function automatic ttts_pkg::slot_t slot_of(ttts_pkg::task_t t);
    return (t == ttts_pkg::TASK_ONE) ? ttts_pkg::SLOT_ONE :
           (t == ttts_pkg::TASK_TWO) ? ttts_pkg::SLOT_TWO : ttts_pkg::SLOT_IDLE;
  endfunction

  function automatic switch_t predict_switch(ttts_pkg::mode_t mode, ttts_pkg::sp_t sp_in,
                                             logic [31:0] delay);
    switch_t         res;
    ttts_pkg::task_t nxt;
    ttts_pkg::slot_t slot;
    res.next_sp = '0;
    res.status = ttts_pkg::ST_DONE;
    if (mode == ttts_pkg::MODE_TICK) begin
      for (int t = 0; t < 2; t++) begin
        if (task_blocked[t]) begin
          ticks_left[t] = ticks_left[t] - 32'd1;
          if (ticks_left[t] == '0) task_blocked[t] = 1'b0;
        end
      end
      // The start context has no stack of its own, so nothing is saved on leaving it.
      if (cur_task == ttts_pkg::TASK_START) begin
        nxt = ttts_pkg::TASK_ONE;
      end else begin
        slot = slot_of(cur_task);
        stored_sp[int'(slot)] = sp_in;
        sp_stored[int'(slot)] = 1'b1;
        if (cur_task == ttts_pkg::TASK_ONE)
          nxt = !task_blocked[1] ? ttts_pkg::TASK_TWO :
                (!task_blocked[0] ? ttts_pkg::TASK_ONE : ttts_pkg::TASK_IDLE);
        else
          nxt = !task_blocked[0] ? ttts_pkg::TASK_ONE :
                (!task_blocked[1] ? ttts_pkg::TASK_TWO : ttts_pkg::TASK_IDLE);
      end
      cur_task = nxt;
      slot = slot_of(nxt);
      res.next_sp = sp_stored[int'(slot)] ? stored_sp[int'(slot)] : boot_sp[int'(slot)];
    end else if (delay == '0) begin
      res.status = ttts_pkg::ST_ZERO_DELAY;
    end else if (cur_task == ttts_pkg::TASK_ONE) begin
      task_blocked[0] = 1'b1;
      ticks_left[0] = delay;
    end else if (cur_task == ttts_pkg::TASK_TWO) begin
      task_blocked[1] = 1'b1;
      ticks_left[1] = delay;
    end else begin
      res.status = ttts_pkg::ST_FAULT;
    end
    res.next_task = cur_task;
    return res;
  endfunction

  function automatic void queue_request(ttts_pkg::mode_t m, ttts_pkg::sp_t sp,
                                        logic [31:0] d);
    sched_req_t r;
    r.mode = m;
    r.saved_sp = sp;
    r.delay_ticks = d;
    pending_requests.push_back(r);
  endfunction

  function automatic ttts_pkg::sp_t pick_sp();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return ttts_pkg::sp_t'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  task automatic load_boot_sps(input ttts_pkg::sp_t sp_one, input ttts_pkg::sp_t sp_two,
                               input ttts_pkg::sp_t sp_idle);
    ttts_pkg::cfg_idx_t reg_order [3] = '{ttts_pkg::CFG_TASK1_SP, ttts_pkg::CFG_TASK2_SP,
                                          ttts_pkg::CFG_IDLE_SP};
    ttts_pkg::sp_t      values [3];
    values = '{sp_one, sp_two, sp_idle};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_order[i];
      cfg_data <= values[i];
      do @(posedge clk); while (!cfg_ready);
      boot_sp[int'(reg_order[i])] = values[i];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_switches();
    while (pending_requests.size() != 0 || in_valid || expected_switches.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Input driver: a new transaction is presented only once the previous one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid)
        expected_switches.push_back(predict_switch(ttts_pkg::mode_t'(in_mode), in_saved_sp,
                                                   in_delay_ticks));
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        in_gap <= $urandom_range(1, 12) - 1;
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        in_mode <= pending_requests[0].mode;
        in_saved_sp <= pending_requests[0].saved_sp;
        in_delay_ticks <= pending_requests[0].delay_ticks;
        in_valid <= 1'b1;
        void'(pending_requests.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and back-pressure.
  always @(posedge clk) begin
    switch_t exp;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_switches.size() == 0) begin
          $error("unexpected result: next_sp %h next_task %0d status %0d",
                 out_next_sp, out_next_task, out_status);
          errors++;
        end else begin
          exp = expected_switches.pop_front();
          if (out_next_sp !== exp.next_sp) begin
            $error("next_sp: expected %h, got %h", exp.next_sp, out_next_sp);
            errors++;
          end
          if (out_next_task !== exp.next_task) begin
            $error("next_task: expected %0d, got %0d", exp.next_task, out_next_task);
            errors++;
          end
          if (out_status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, out_status);
            errors++;
          end
        end
      end
      if (out_gap != 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(1, 12) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_boot_sps('1, '0, 32'h5A5A_A5A5);

    // Delays from the start context: zero is ignored, anything else is a fault.
    queue_request(ttts_pkg::MODE_DELAY, 32'h1234_5678, '0);
    queue_request(ttts_pkg::MODE_DELAY, '0, 32'd5);
    queue_request(ttts_pkg::MODE_DELAY, '1, '1);
    // The first tick always lands on task one with its boot pointer.
    queue_request(ttts_pkg::MODE_TICK, '1, '1);
    queue_request(ttts_pkg::MODE_TICK, '0, '0);
    queue_request(ttts_pkg::MODE_TICK, '1, 32'd9);
    queue_request(ttts_pkg::MODE_DELAY, $urandom, '0);
    queue_request(ttts_pkg::MODE_DELAY, $urandom, 32'd2);
    // A second delay while blocked replaces the count.
    queue_request(ttts_pkg::MODE_DELAY, $urandom, '1);
    queue_request(ttts_pkg::MODE_DELAY, $urandom, 32'd3);
    queue_request(ttts_pkg::MODE_TICK, 32'h1234_5678, $urandom);
    queue_request(ttts_pkg::MODE_DELAY, $urandom, 32'd4);
    // Both tasks are blocked now, so this tick goes to idle.
    queue_request(ttts_pkg::MODE_TICK, 32'h8765_4321, $urandom);
    queue_request(ttts_pkg::MODE_DELAY, $urandom, 32'd7);
    queue_request(ttts_pkg::MODE_DELAY, $urandom, '0);
    queue_request(ttts_pkg::MODE_TICK, 32'h0000_0001, $urandom);
    queue_request(ttts_pkg::MODE_TICK, 32'h8000_0000, $urandom);
    queue_request(ttts_pkg::MODE_TICK, 32'h7FFF_FFFF, $urandom);
    queue_request(ttts_pkg::MODE_DELAY, $urandom, 32'd1);
    queue_request(ttts_pkg::MODE_TICK, $urandom, $urandom);
    queue_request(ttts_pkg::MODE_DELAY, $urandom, 32'd1);
    queue_request(ttts_pkg::MODE_TICK, $urandom, $urandom);
    queue_request(ttts_pkg::MODE_TICK, $urandom, $urandom);
    drain_switches();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: load_boot_sps('1, '1, '1);
        1: load_boot_sps('0, '0, '0);
        default: load_boot_sps(pick_sp(), pick_sp(), pick_sp());
      endcase
      if (phase == 4) quiet <= 1'b1;
      for (int n = 0; n < 260; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          queue_request(ttts_pkg::MODE_TICK, pick_sp(), $urandom);
        end else if (pick < 78) begin
          queue_request(ttts_pkg::MODE_DELAY, $urandom, $urandom_range(1, 6));
        end else if (pick < 86) begin
          queue_request(ttts_pkg::MODE_DELAY, $urandom, '0);
        end else if (pick < 93) begin
          // A full-range count would park the task for the rest of the run, so a
          // short delay follows at once and replaces it.
          queue_request(ttts_pkg::MODE_DELAY, $urandom, $urandom);
          queue_request(ttts_pkg::MODE_DELAY, $urandom, $urandom_range(1, 4));
        end else begin
          queue_request(ttts_pkg::MODE_DELAY, $urandom, $urandom_range(7, 40));
        end
      end
      drain_switches();
    end

    if (errors == 0 && expected_switches.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+hw/rtl
hw/rtl/ttts_pkg.sv
hw/rtl/two_task_tick_scheduler_top.sv
dv/tb.sv
